@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the line framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/glf_pkg.sv @@
package glf_pkg;

    localparam int MaxLine = 40;
    localparam int LenW = 6;
    localparam logic [26:0] NumWrap = 27'd99999999;
    localparam logic [26:0] ValMax = 27'd134217727;

    localparam logic [1:0] CMD_GCODE = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] ST_BYTE = 3'd0;
    localparam logic [2:0] ST_CONSUMED = 3'd1;
    localparam logic [2:0] ST_OK = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_TOO_LONG = 3'd6;
    localparam logic [2:0] ST_BUSY = 3'd7;

    localparam logic [1:0] RK_NONE = 2'd0;
    localparam logic [1:0] RK_OK = 2'd1;
    localparam logic [1:0] RK_RESEND = 2'd2;
    localparam logic [1:0] RK_OTHER = 2'd3;

    localparam logic [0:0] REG_FIRST = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    // emit phases
    typedef enum logic [2:0] {
        PH_N = 3'd0,
        PH_NUM = 3'd1,
        PH_SP = 3'd2,
        PH_TEXT = 3'd3,
        PH_STAR = 3'd4,
        PH_CHK = 3'd5,
        PH_NL = 3'd6
    } t_phase;

    typedef struct packed {
        logic       take;       // process the input item (single-result path)
        logic       conv_start; // start binary-to-decimal of the line number
        logic       conv_step;
        logic       emit_start;
        logic       emit_step;  // one framed byte delivered
        logic       emit_done;  // finish emission: enter awaiting
    } t_cmd;

    typedef struct packed {
        logic       want_emit;  // current item starts a frame
        logic       conv_done;
        logic       emit_last;  // the byte on display is the newline
    } t_sts;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

@@ hw/rtl/glf_ctrl.sv @@
module glf_ctrl import glf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ONE  = 5'b00010,
        S_CONV = 5'b00100,
        S_EMIT = 5'b01000,
        S_ELST = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_sts.want_emit) begin
                        o_cmd.conv_start = 1'b1;
                        n_state = S_CONV;
                    end else begin
                        o_cmd.take = 1'b1;
                        n_state = S_ONE;
                    end
                end
            end
            S_ONE: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_sts.conv_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.emit_step = 1'b1;
                    if (i_sts.emit_last) begin
                        o_cmd.emit_done = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/glf_datapath.sv @@
module glf_datapath import glf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic [26:0] o_first,
    output logic [31:0] o_timeout,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_last
);

    logic [7:0]      r_store [MaxLine];
    logic [LenW-1:0] r_len, r_kept;
    logic            r_cmt, r_long;
    logic [26:0]     r_num, r_first;
    logic [31:0]     r_tmo, r_wait;
    logic            r_await;
    logic [3:0]      r_rpos;
    logic [1:0]      r_rkind;
    logic [26:0]     r_rval;
    logic [2:0]      r_stat;

    // decimal conversion: repeated subtract of powers of ten, 8 digits
    logic [26:0]     r_cv;
    logic [2:0]      r_dpos;
    logic [3:0]      r_dig [8];
    logic [3:0]      r_dcnt;
    logic            r_conv_done;
    logic [3:0]      r_nd;

    t_phase          r_ph;
    logic [LenW-1:0] r_ti;
    logic [3:0]      r_di;
    logic [7:0]      r_x;
    logic [7:0]      r_byte;
    logic [1:0]      r_ci;
    logic [7:0]      r_c;
    logic [7:0]      r_tdata;
    logic [LenW-1:0] rd_addr;

    function automatic logic [26:0] pow10(input logic [2:0] p);
        logic [26:0] v;
        unique case (p)
            3'd0: v = 27'd1;
            3'd1: v = 27'd10;
            3'd2: v = 27'd100;
            3'd3: v = 27'd1000;
            3'd4: v = 27'd10000;
            3'd5: v = 27'd100000;
            3'd6: v = 27'd1000000;
            default: v = 27'd10000000;
        endcase
        return v;
    endfunction

    // hundreds, tens and ones of a byte: compare and subtract, then multiply by 205/2048
    function automatic logic [11:0] dec3(input logic [7:0] v);
        logic [7:0]  r;
        logic [7:0]  o;
        logic [15:0] p;
        logic [3:0]  h;
        logic [3:0]  t;
        if (v >= 8'd200) begin
            h = 4'd2;
            r = v - 8'd200;
        end else if (v >= 8'd100) begin
            h = 4'd1;
            r = v - 8'd100;
        end else begin
            h = 4'd0;
            r = v;
        end
        p = {8'd0, r} * 16'd205;
        t = p[14:11];
        o = r - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
        return {h, t, o[3:0]};
    endfunction

    logic        is_dig;
    logic [30:0] dig_sum;
    logic [26:0] dig_sat;
    logic        resend_ok;
    logic        neg;

    assign is_dig = i_in_byte >= "0" && i_in_byte <= "9";
    assign dig_sum = ({4'd0, r_rval} << 3) + ({4'd0, r_rval} << 1)
                     + {23'd0, i_in_byte - 8'd48};
    assign dig_sat = (dig_sum > {4'd0, ValMax}) ? ValMax : dig_sum[26:0];
    assign neg = r_rpos == 4'd9 || r_rpos == 4'd11 || r_rpos == 4'd13;
    assign resend_ok = r_rkind == RK_RESEND && r_rpos >= 4'd7 && r_rval == r_num
                       && !(neg && r_rval != 27'd0);

    always_comb begin
        o_sts.want_emit = 1'b0;
        if (i_command == CMD_GCODE && !r_await && i_in_byte == 8'd10 && !r_long
            && r_kept != '0) begin
            o_sts.want_emit = 1'b1;
        end
        if (i_command == CMD_REPLY && r_await && i_in_byte == 8'd10 && resend_ok) begin
            o_sts.want_emit = 1'b1;
        end
        o_sts.conv_done = r_conv_done;
        o_sts.emit_last = r_ph == PH_NL;
    end

    assign o_first = r_first;
    assign o_timeout = r_tmo;

    function automatic logic [7:0] resend_ch(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0: c = "R";
            4'd1: c = "e";
            4'd2: c = "s";
            4'd3: c = "e";
            4'd4: c = "n";
            4'd5: c = "d";
            default: c = ":";
        endcase
        return c;
    endfunction

    logic [11:0] chk_bcd;
    logic [7:0]  chk_dig;
    assign chk_bcd = dec3(r_c);
    always_comb begin
        unique case (r_ci)
            2'd2: chk_dig = {4'd3, chk_bcd[11:8]};
            2'd1: chk_dig = {4'd3, chk_bcd[7:4]};
            default: chk_dig = {4'd3, chk_bcd[3:0]};
        endcase
    end

    always_comb begin
        unique case (r_ph)
            PH_N: r_byte = "N";
            PH_NUM: r_byte = {4'd3, r_dig[r_di[2:0]]};
            PH_SP: r_byte = " ";
            PH_TEXT: r_byte = r_tdata;
            PH_STAR: r_byte = "*";
            PH_CHK: r_byte = chk_dig;
            PH_NL: r_byte = 8'd10;
            default: r_byte = 8'd10;
        endcase
    end

    assign o_out_byte = r_stat == ST_BYTE ? r_byte : 8'd0;
    assign o_status = r_stat;
    assign o_last = r_stat != ST_BYTE || r_ph == PH_NL;

    // prefetch the next text byte when the current one leaves
    assign rd_addr = (i_cmd.emit_step && r_ph == PH_TEXT && r_ti + 1'b1 < r_kept)
                     ? r_ti + 1'b1 : r_ti;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_command == CMD_GCODE && !r_await && i_in_byte != 8'd10
            && !r_cmt && i_in_byte != ";" && r_len < LenW'(MaxLine)) begin
            r_store[r_len] <= i_in_byte;
        end
        r_tdata <= r_store[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_kept <= '0; r_cmt <= 1'b0; r_long <= 1'b0;
            r_first <= 27'd1; r_num <= 27'd1; r_tmo <= 32'd30000; r_wait <= '0;
            r_await <= 1'b0; r_rpos <= '0; r_rkind <= RK_NONE; r_rval <= '0;
            r_stat <= ST_CONSUMED; r_conv_done <= 1'b0; r_ph <= PH_N;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FIRST: begin
                        r_first <= i_cfg_data[26:0];
                        if (!r_await) begin
                            r_num <= i_cfg_data[26:0] > NumWrap ? 27'd0 : i_cfg_data[26:0];
                        end
                    end
                    default: r_tmo <= i_cfg_data;
                endcase
            end
            if (i_cmd.take) begin
                r_stat <= ST_CONSUMED;
                priority if (i_command == CMD_GCODE) begin
                    priority if (r_await) begin
                        r_stat <= ST_BUSY;
                    end else if (i_in_byte != 8'd10) begin
                        if (!r_cmt) begin
                            priority if (i_in_byte == ";") begin
                                r_cmt <= 1'b1;
                            end else if (r_len < LenW'(MaxLine)) begin
                                r_len <= r_len + 1'b1;
                                if (!is_space(i_in_byte)) r_kept <= r_len + 1'b1;
                            end else begin
                                r_long <= 1'b1;
                            end
                        end
                    end else begin
                        r_stat <= r_long ? ST_TOO_LONG : ST_EMPTY;
                        r_len <= '0; r_kept <= '0; r_cmt <= 1'b0; r_long <= 1'b0;
                        r_wait <= '0; r_rpos <= '0; r_rkind <= RK_NONE; r_rval <= '0;
                    end
                end else if (i_command == CMD_REPLY) begin
                    if (r_await) begin
                        r_wait <= '0;
                        if (i_in_byte != 8'd10) begin
                            unique case (r_rkind)
                                RK_NONE: begin
                                    priority if (i_in_byte == "o") begin
                                        r_rkind <= RK_OK; r_rpos <= 4'd1;
                                    end else if (i_in_byte == "R") begin
                                        r_rkind <= RK_RESEND; r_rpos <= 4'd1;
                                    end else begin
                                        r_rkind <= RK_OTHER;
                                    end
                                end
                                RK_OK: begin
                                    if (r_rpos == 4'd1 && i_in_byte == "k") r_rpos <= 4'd2;
                                    else r_rkind <= RK_OTHER;
                                end
                                RK_RESEND: begin
                                    priority if (r_rpos < 4'd7) begin
                                        if (i_in_byte == resend_ch(r_rpos))
                                            r_rpos <= r_rpos + 4'd1;
                                        else r_rkind <= RK_OTHER;
                                    end else if (r_rpos == 4'd7) begin
                                        priority if (is_space(i_in_byte)) begin
                                        end else if (i_in_byte == "+") begin
                                            r_rpos <= 4'd8;
                                        end else if (i_in_byte == "-") begin
                                            r_rpos <= 4'd9;
                                        end else if (is_dig) begin
                                            r_rval <= dig_sat; r_rpos <= 4'd10;
                                        end else begin
                                            r_rpos <= 4'd12;
                                        end
                                    end else if (r_rpos == 4'd8 || r_rpos == 4'd9) begin
                                        if (is_dig) begin
                                            r_rval <= dig_sat;
                                            r_rpos <= r_rpos == 4'd8 ? 4'd10 : 4'd11;
                                        end else r_rpos <= 4'd12;
                                    end else if (r_rpos == 4'd10 || r_rpos == 4'd11) begin
                                        if (is_dig) r_rval <= dig_sat;
                                        else r_rpos <= r_rpos + 4'd2;
                                    end else begin
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end else begin
                            priority if (r_rkind == RK_OK && r_rpos == 4'd2) begin
                                r_num <= r_num >= NumWrap ? 27'd0 : r_num + 27'd1;
                                r_stat <= ST_OK;
                                r_await <= 1'b0;
                                r_len <= '0; r_kept <= '0; r_cmt <= 1'b0; r_long <= 1'b0;
                            end else if (r_rkind == RK_RESEND && r_rpos >= 4'd7) begin
                                r_stat <= ST_MISMATCH;
                                r_await <= 1'b0;
                                r_len <= '0; r_kept <= '0; r_cmt <= 1'b0; r_long <= 1'b0;
                            end else begin
                            end
                            r_rpos <= '0; r_rkind <= RK_NONE; r_rval <= '0;
                        end
                    end
                end else if (i_command == CMD_TICK && r_await) begin
                    if ((r_wait != 32'hFFFF_FFFF ? r_wait + 32'd1 : r_wait) >= r_tmo) begin
                        r_stat <= ST_TIMEOUT;
                        r_await <= 1'b0; r_wait <= '0;
                        r_len <= '0; r_kept <= '0; r_cmt <= 1'b0; r_long <= 1'b0;
                        r_rpos <= '0; r_rkind <= RK_NONE; r_rval <= '0;
                    end else if (r_wait != 32'hFFFF_FFFF) begin
                        r_wait <= r_wait + 32'd1;
                    end
                end else begin
                end
            end
            if (i_cmd.conv_start) begin
                r_cv <= r_num; r_dpos <= 3'd7; r_dcnt <= '0; r_conv_done <= 1'b0;
                r_nd <= 4'd1;
            end
            if (i_cmd.conv_step && !r_conv_done) begin
                if (r_cv >= pow10(r_dpos)) begin
                    r_cv <= r_cv - pow10(r_dpos);
                    r_dcnt <= r_dcnt + 4'd1;
                end else begin
                    r_dig[r_dpos] <= r_dcnt;
                    if (r_dcnt != 4'd0 && r_nd == 4'd1 && r_dpos != 3'd0)
                        r_nd <= {1'b0, r_dpos} + 4'd1;
                    r_dcnt <= '0;
                    if (r_dpos == 3'd0) r_conv_done <= 1'b1;
                    else r_dpos <= r_dpos - 3'd1;
                end
            end
            if (i_cmd.emit_start) begin
                r_stat <= ST_BYTE; r_ph <= PH_N; r_x <= "N";
                r_di <= r_nd - 4'd1;
                r_ti <= '0; r_conv_done <= 1'b0;
                r_rpos <= '0; r_rkind <= RK_NONE; r_rval <= '0;
                r_wait <= '0; r_len <= '0; r_cmt <= 1'b0;
            end
            if (i_cmd.emit_step) begin
                unique case (r_ph)
                    PH_N: r_ph <= PH_NUM;
                    PH_NUM: begin
                        r_x <= r_x ^ r_byte;
                        if (r_di == 4'd0) r_ph <= PH_SP;
                        else r_di <= r_di - 4'd1;
                    end
                    PH_SP: begin
                        r_x <= r_x ^ r_byte;
                        r_ph <= (r_kept == '0) ? PH_STAR : PH_TEXT;
                    end
                    PH_TEXT: begin
                        r_x <= r_x ^ r_byte;
                        if (r_ti + 1'b1 >= r_kept) r_ph <= PH_STAR;
                        else r_ti <= r_ti + 1'b1;
                    end
                    PH_STAR: begin
                        r_c <= r_x;
                        r_ci <= r_x >= 8'd100 ? 2'd2 : (r_x >= 8'd10 ? 2'd1 : 2'd0);
                        r_ph <= PH_CHK;
                    end
                    PH_CHK: begin
                        if (r_ci == 2'd0) r_ph <= PH_NL;
                        else r_ci <= r_ci - 2'd1;
                    end
                    default: r_ph <= PH_N;
                endcase
            end
            if (i_cmd.emit_done) begin
                r_await <= 1'b1;
                r_stat <= ST_CONSUMED;
                r_ph <= PH_N;
            end
        end
    end

endmodule

@@ hw/rtl/gcode_line_framer_with_resend.sv @@
// G-code line framer with resend handling.
// Input channel: i_valid/o_stall carrying i_command (G-code byte, reply byte, tick)
// and i_in_byte. Output channel: o_valid/i_stall carrying o_out_byte, o_status,
// o_last; o_last marks the final result of each input transaction.
// An item that gives one result is accepted, then held in the result register.
// A newline that frames a line (or a matching resend) first runs a digit-by-
// subtraction decimal converter for the line number, then emits one framed
// byte per cycle while the receiver does not stall.
// One item is in flight at a time; the next is accepted after the last result.
// When the receiver stalls, the result register holds its value.
// Synchronous reset clears the line buffer counts, the awaiting flag and the
// reply parser, and loads line number 1 and a timeout of 30000 ticks.
// APB: register 0 at 0x0 is first_line_number, register 1 at 0x4 is the timeout.
module gcode_line_framer_with_resend import glf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_status,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    t_cmd        cmd;
    t_sts        sts;
    logic        cfg_we;
    logic [26:0] first;
    logic [31:0] tmo;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && paddr[1:0] == 2'b00;
    assign prdata = paddr[2] ? tmo : {5'd0, first};

    glf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    glf_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_command  (i_command),
        .i_in_byte  (i_in_byte),
        .i_cfg_we   (cfg_we && paddr[2:2] <= 1'b1),
        .i_cfg_idx  (paddr[2:2]),
        .i_cfg_data (pwdata),
        .o_first    (first),
        .o_timeout  (tmo),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_byte (o_out_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    `ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, o_valid, o_stall, "accept during output")
    `ASSERT_IMPL(a_byte_zero, i_clk, i_rst_n, o_valid && o_status != ST_BYTE, o_out_byte == 8'd0,
        "nonzero byte on status result")
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_valid,
        "output continues after last")

endmodule

@@ verif/framer_checker.sv @@
`timescale 1ns / 1ps

module framer_checker import glf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_in_byte,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [7:0]  o_out_byte,
    input  logic [2:0]  o_status,
    input  logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          errors,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } framer_result_t;

    framer_result_t expected_results[$];

    logic [26:0] first_num;
    logic [31:0] timeout_ticks;
    logic [7:0]  line_buf [MaxLine];
    int unsigned line_len, kept_len;
    bit          in_comment, overlong, awaiting;
    logic [26:0] line_num;
    int unsigned reply_pos;
    logic [1:0]  reply_kind;
    logic [26:0] resend_num;
    logic [31:0] tick_count;

    function automatic bit is_ws(logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    task automatic push(logic [7:0] b, logic [2:0] st);
        expected_results.push_back('{b, st, 1'b0});
    endtask

    task automatic clear_reply();
        reply_pos = 0;
        reply_kind = RK_NONE;
        resend_num = '0;
    endtask

    task automatic drop_line();
        awaiting = 0;
        line_len = 0;
        kept_len = 0;
        in_comment = 0;
        overlong = 0;
        tick_count = '0;
        clear_reply();
    endtask

    task automatic frame_line();
        string       num_txt;
        logic [7:0]  chk;
        num_txt = $sformatf("%0d", line_num);
        chk = "N";
        push("N", ST_BYTE);
        foreach (num_txt[i]) begin
            chk ^= num_txt[i];
            push(num_txt[i], ST_BYTE);
        end
        chk ^= " ";
        push(" ", ST_BYTE);
        for (int i = 0; i < kept_len; i++) begin
            chk ^= line_buf[i];
            push(line_buf[i], ST_BYTE);
        end
        push("*", ST_BYTE);
        num_txt = $sformatf("%0d", chk);
        foreach (num_txt[i]) push(num_txt[i], ST_BYTE);
        push(8'd10, ST_BYTE);
    endtask

    task automatic add_digit(logic [7:0] b);
        longint unsigned v;
        v = longint'(resend_num) * 10 + (b - "0");
        resend_num = v > ValMax ? ValMax : v[26:0];
    endtask

    task automatic parse_reply(logic [7:0] b);
        string rs;
        bit    dig;
        rs = "Resend:";
        dig = b >= "0" && b <= "9";
        case (reply_kind)
            RK_NONE: begin
                if (b == "o") begin
                    reply_kind = RK_OK;
                    reply_pos = 1;
                end else if (b == "R") begin
                    reply_kind = RK_RESEND;
                    reply_pos = 1;
                end else reply_kind = RK_OTHER;
            end
            RK_OK: begin
                if (reply_pos == 1 && b == "k") reply_pos = 2;
                else reply_kind = RK_OTHER;
            end
            RK_RESEND: begin
                if (reply_pos < 7) begin
                    if (b == rs[reply_pos]) reply_pos++;
                    else reply_kind = RK_OTHER;
                end else if (reply_pos == 7) begin
                    if (is_ws(b)) ;
                    else if (b == "+") reply_pos = 8;
                    else if (b == "-") reply_pos = 9;
                    else if (dig) begin
                        add_digit(b);
                        reply_pos = 10;
                    end else reply_pos = 12;
                end else if (reply_pos == 8 || reply_pos == 9) begin
                    if (dig) begin
                        add_digit(b);
                        reply_pos = reply_pos == 8 ? 10 : 11;
                    end else reply_pos = 12;
                end else if (reply_pos == 10 || reply_pos == 11) begin
                    if (dig) add_digit(b);
                    else reply_pos += 2;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_item(logic [1:0] cmd, logic [7:0] b);
        bit neg;
        int n0;
        n0 = expected_results.size();
        if (cmd == CMD_GCODE) begin
            if (awaiting) push(0, ST_BUSY);
            else if (b != 8'd10) begin
                if (!in_comment) begin
                    if (b == ";") in_comment = 1;
                    else if (line_len < MaxLine) begin
                        line_buf[line_len] = b;
                        line_len++;
                        if (!is_ws(b)) kept_len = line_len;
                    end else overlong = 1;
                end
                push(0, ST_CONSUMED);
            end else if (overlong) begin
                drop_line();
                push(0, ST_TOO_LONG);
            end else if (kept_len == 0) begin
                drop_line();
                push(0, ST_EMPTY);
            end else begin
                frame_line();
                awaiting = 1;
                line_len = 0;
                in_comment = 0;
                tick_count = '0;
                clear_reply();
            end
        end else if (cmd == CMD_REPLY) begin
            if (!awaiting) push(0, ST_CONSUMED);
            else if (b != 8'd10) begin
                tick_count = '0;
                parse_reply(b);
                push(0, ST_CONSUMED);
            end else begin
                tick_count = '0;
                if (reply_kind == RK_OK && reply_pos == 2) begin
                    line_num = line_num >= NumWrap ? '0 : line_num + 1;
                    drop_line();
                    push(0, ST_OK);
                end else if (reply_kind == RK_RESEND && reply_pos >= 7) begin
                    neg = reply_pos == 9 || reply_pos == 11 || reply_pos == 13;
                    if (resend_num == line_num && !(neg && resend_num != 0)) begin
                        clear_reply();
                        frame_line();
                    end else begin
                        drop_line();
                        push(0, ST_MISMATCH);
                    end
                end else begin
                    clear_reply();
                    push(0, ST_CONSUMED);
                end
            end
        end else if (cmd == CMD_TICK && awaiting) begin
            if (tick_count != '1) tick_count++;
            if (tick_count >= (timeout_ticks == 0 ? 1 : timeout_ticks)) begin
                drop_line();
                push(0, ST_TIMEOUT);
            end else push(0, ST_CONSUMED);
        end else push(0, ST_CONSUMED);
        expected_results[expected_results.size() - 1].last = 1'b1;
        if (expected_results.size() == n0) $display("%0t internal predictor error", $time);
    endtask

    framer_result_t got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_num = 27'd1;
            timeout_ticks = 32'd30000;
            line_num = 27'd1;
            drop_line();
            expected_results.delete();
            errors <= 0;
            results_seen <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == {REG_FIRST, 2'b00}) begin
                    first_num = pwdata[26:0];
                    if (!awaiting) line_num = first_num > NumWrap ? '0 : first_num;
                end else if (paddr == {REG_TIMEOUT, 2'b00}) timeout_ticks = pwdata;
            end
            if (i_valid && !o_stall) predict_item(i_command, i_in_byte);
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                got = '{o_out_byte, o_status, o_last};
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected transaction: actual %h/%0d/%0b", $time,
                             o_out_byte, o_status, o_last);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch: expected %h/%0d/%0b actual %h/%0d/%0b",
                                 $time, want.data, want.status, want.last,
                                 got.data, got.status, got.last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    assign pending = expected_results.size();

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench import glf_pkg::*;;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [1:0]  i_command;
    logic [7:0]  i_in_byte;
    logic        o_valid, i_stall;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_status;
    logic        o_last;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          errors, pending, results_seen;
    int          items_sent, idle_cycles;
    bit          hold_long, timed_out;
    logic [26:0] cur_num;

    gcode_line_framer_with_resend uut (.*);

    framer_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_in_byte,
        .o_valid, .i_stall, .o_out_byte, .o_status, .o_last,
        .psel, .penable, .pwrite, .paddr, .pwdata,
        .errors, .pending, .results_seen
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        int w;
        i_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                i_stall <= 1;
                repeat (300) @(posedge i_clk);
                i_stall <= 0;
                hold_long = 0;
            end else begin
                w = $urandom_range(0, 4);
                if ($urandom_range(0, 3) == 0) w = 0;
                if (w != 0) begin
                    i_stall <= 1;
                    repeat (w) @(posedge i_clk);
                    i_stall <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !timed_out) begin
            timed_out = 1;
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 4);
        if (items_sent % 60 < 15) gap = 0;
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_command <= cmd;
        i_in_byte <= b;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send(CMD_GCODE, s[i]);
    endtask

    task automatic send_reply(string s);
        foreach (s[i]) send(CMD_REPLY, s[i]);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [0:0] idx, logic [31:0] val);
        psel <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        pwrite <= 1;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge i_clk);
        if (idx == REG_FIRST) cur_num = val[26:0] > NumWrap ? '0 : val[26:0];
    endtask

    task automatic random_line();
        int len;
        logic [7:0] b;
        len = $urandom_range(0, 9) == 0 ? $urandom_range(38, 45) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 5))
                0: b = $urandom_range(0, 255);
                1: b = " ";
                2: b = ";";
                default: b = $urandom_range(33, 126);
            endcase
            if (b == 8'd10) b = "G";
            send(CMD_GCODE, b);
        end
        send(CMD_GCODE, 8'd10);
    endtask

    task automatic random_reply();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                send_reply("ok");
                cur_num = cur_num >= NumWrap ? '0 : cur_num + 1;
            end
            4, 5: send_reply($sformatf("Resend: %0d", cur_num));
            6: send_reply($sformatf("Resend:-%0d", $urandom_range(0, 5)));
            7: send_reply({"Resend:", 8'($urandom_range(0, 255) | 8'd1)});
            8: repeat ($urandom_range(1, 3)) send(CMD_TICK, $urandom_range(0, 255));
            default: begin
                send(CMD_REPLY, $urandom_range(0, 255));
                send(CMD_GCODE, $urandom_range(0, 255));
                send(3, $urandom_range(0, 255));
            end
        endcase
        send(CMD_REPLY, 8'd10);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_command = CMD_GCODE;
        i_in_byte = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        items_sent = 0;
        hold_long = 0;
        timed_out = 0;
        cur_num = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_text("G1 X10 ; move\n");
        send_reply("ok\n");
        send_text({"M", 8'd0, 8'd255, " \t\r\n"});
        send_reply("Resend:+2\n");
        send_reply("Resend:3\n");
        send(CMD_GCODE, 8'd10);
        send_text("   ;x\n");
        send(CMD_REPLY, "o");
        send(3, 8'hAA);
        drain();
        apb_write(REG_FIRST, 32'd99999999);
        apb_write(REG_TIMEOUT, 32'd2);
        send_text("G28\n");
        send(CMD_GCODE, "X");
        send(CMD_TICK, 0);
        send(CMD_TICK, 0);
        drain();
        apb_write(REG_FIRST, 32'h07FFFFFF);
        repeat (45) send(CMD_GCODE, "A");
        send(CMD_GCODE, 8'd10);
        drain();

        apb_write(REG_TIMEOUT, 32'd0);
        apb_write(REG_FIRST, 32'd0);
        hold_long = 1;
        for (int k = 0; k < 12; k++) begin
            random_line();
            if (pending > 3 || $urandom_range(0, 1)) random_reply();
        end
        drain();
        apb_write(REG_TIMEOUT, 32'hFFFFFFFF);
        apb_write(REG_FIRST, 32'd99999998);
        while (items_sent < 280) begin
            random_line();
            random_reply();
            if ($urandom_range(0, 15) == 0) drain();
        end
        drain();
        apb_write(REG_TIMEOUT, 32'd3);
        apb_write(REG_FIRST, 32'd1);
        repeat (5) begin
            random_line();
            repeat (3) send(CMD_TICK, 0);
        end
        drain();

        $display("covered %0d input items and %0d results over several register settings",
                 items_sent, results_seen);
        $display("including busy, comment, overlong, resend, timeout and wrap cases");
        if (errors == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule
